// File: rtl/core/vprs_pkg.sv
// shared types and constants for the valve pwm ramp sequencer
`default_nettype none

package vprs_pkg;

    localparam int unsigned DUTY_W  = 8;
    localparam int unsigned PHASE_W = 4;
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned CIDX_W  = 1;

    // sequence phases
    typedef enum logic [PHASE_W-1:0] {
        PH_OUT_STOP   = 4'd0,
        PH_OUT_CLOSE  = 4'd1,
        PH_OUT_CLOSED = 4'd2,
        PH_OUT_START  = 4'd3,
        PH_OUT_OPEN   = 4'd4,
        PH_OUT_OPENED = 4'd5,
        PH_IN_START   = 4'd6,
        PH_IN_CLOSE   = 4'd7,
        PH_IN_CLOSED  = 4'd8,
        PH_IN_RUN     = 4'd9,
        PH_IN_STOP    = 4'd10,
        PH_IN_SCLOSE  = 4'd11,
        PH_IN_DONE    = 4'd12
    } t_phase;

    // commands carried in the input word
    typedef enum logic [CMD_W-1:0] {
        CMD_STOP_DEFLATE  = 2'd0,
        CMD_START_DEFLATE = 2'd1,
        CMD_START_INFLATE = 2'd2,
        CMD_STOP_INFLATE  = 2'd3
    } t_cmd;

    // item kind in tuser
    localparam logic KIND_TICK    = 1'b0;
    localparam logic KIND_COMMAND = 1'b1;

    // configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_CLOSE_START_CAP  = 1'd0;
    localparam logic [CIDX_W-1:0] CFG_OPEN_START_FLOOR = 1'd1;

    localparam logic [DUTY_W-1:0] CAP_RESET   = 8'd160;
    localparam logic [DUTY_W-1:0] FLOOR_RESET = 8'd128;
    localparam logic [DUTY_W-1:0] DUTY_MAX    = 8'd255;
    localparam logic [DUTY_W-1:0] DUTY_ZERO   = 8'd0;

endpackage

`default_nettype wire

// File: rtl/core/valve_pwm_ramp_sequencer_unit.sv
// valve pwm ramp sequencer: phase, duty and inflate/deflate flag control
`default_nettype none

// Valve PWM ramp sequencer. Every input word is either a command (tuser = 1,
// command in tdata[1:0]) that only moves the phase to an entry phase, or a
// control tick (tuser = 0) that runs one step of the sequence: closing ramps
// start at the current duty capped at close_start_cap and fall by one per
// tick to 0, the opening ramp starts at the current duty raised to
// open_start_floor and rises by one per tick to 255, and the end of a ramp
// sets the phase and the inflate/deflate flags. Every input word gives exactly
// one output word carrying the state after that word, on the master side in the
// cycle after acceptance, and one word is taken per cycle unless the output
// stalls: the whole step is a compare, an increment or decrement and a phase
// select feeding the state registers, which double as the output register.
// A new word is taken whenever the output slot is empty or is being drained
// in the same cycle. Reset leaves phase 12 (stopped after inflate), duty 0,
// both flags off, cap 160 and floor 128. Configuration writes are accepted
// every cycle (o_cfg_ready is tied high) and apply from the next tick on.
module valve_pwm_ramp_sequencer_unit
    import vprs_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // slave side
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [7:0]           s_axis_tdata,   // [1:0] command, [7:2] zero
    input  wire logic                 s_axis_tuser,   // [0] kind
    // master side
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [15:0]               m_axis_tdata,   // [7:0] valve_duty, [8] inflate_on,
                                                      // [9] deflate_on, [13:10] phase_now,
                                                      // [15:14] zero
    // configuration write channel
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CIDX_W-1:0]    i_cfg_index,
    input  wire logic [DUTY_W-1:0]    i_cfg_data
);

    // configuration
    logic [DUTY_W-1:0] r_cap;
    logic [DUTY_W-1:0] r_floor;

    // sequence state, also the output register
    t_phase            r_phase,   n_phase;
    logic [DUTY_W-1:0] r_duty,    n_duty;
    logic              r_inflate, n_inflate;
    logic              r_deflate, n_deflate;
    logic              r_out_valid;

    logic              s_fire;
    logic [DUTY_W-1:0] close_v;     // closing ramp step result
    logic [DUTY_W-1:0] open_v;      // opening ramp step result
    logic [DUTY_W-1:0] capped;
    logic [DUTY_W-1:0] floored;
    t_cmd              cmd;

    assign o_cfg_ready   = 1'b1;
    // take a word when the output slot is free or drains this cycle
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign s_fire        = s_axis_tvalid && s_axis_tready;
    assign cmd           = t_cmd'(s_axis_tdata[CMD_W-1:0]);

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_phase, r_deflate, r_inflate, r_duty};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap   <= CAP_RESET;
            r_floor <= FLOOR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_CLOSE_START_CAP:  r_cap   <= i_cfg_data;
                CFG_OPEN_START_FLOOR: r_floor <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // ramp arithmetic
    always_comb begin
        capped  = (r_duty > r_cap)   ? r_cap   : r_duty;
        close_v = (capped != DUTY_ZERO) ? capped - 8'd1 : capped;
        floored = (r_duty < r_floor) ? r_floor : r_duty;
        open_v  = (floored != DUTY_MAX) ? floored + 8'd1 : floored;
    end

    // next state for one word
    always_comb begin
        n_phase   = r_phase;
        n_duty    = r_duty;
        n_inflate = r_inflate;
        n_deflate = r_deflate;
        if (s_axis_tuser == KIND_COMMAND) begin
            unique case (cmd)
                CMD_STOP_DEFLATE:  n_phase = PH_OUT_STOP;
                CMD_START_DEFLATE: n_phase = PH_OUT_START;
                CMD_START_INFLATE: n_phase = PH_IN_START;
                CMD_STOP_INFLATE:  n_phase = PH_IN_STOP;
                default:           n_phase = r_phase;
            endcase
        end else begin
            unique case (r_phase)
                PH_OUT_STOP: begin
                    n_deflate = 1'b0;
                    n_inflate = 1'b0;
                    n_phase   = (r_duty != DUTY_ZERO) ? PH_OUT_CLOSE : PH_OUT_CLOSED;
                end
                PH_OUT_CLOSE, PH_IN_SCLOSE, PH_IN_CLOSE: begin
                    n_duty = close_v;
                    if (close_v == DUTY_ZERO) begin
                        n_deflate = 1'b0;
                        n_phase   = (r_phase == PH_OUT_CLOSE) ? PH_OUT_CLOSED :
                                    (r_phase == PH_IN_CLOSE)  ? PH_IN_CLOSED  : PH_IN_DONE;
                    end
                end
                PH_OUT_START: begin
                    n_deflate = 1'b1;
                    n_inflate = 1'b0;
                    n_phase   = (r_duty != DUTY_MAX) ? PH_OUT_OPEN : PH_OUT_OPENED;
                end
                PH_OUT_OPEN: begin
                    n_duty = open_v;
                    if (open_v == DUTY_MAX) begin
                        n_phase   = PH_OUT_OPENED;
                        n_deflate = 1'b1;
                    end
                end
                PH_IN_START: begin
                    n_phase = (r_duty != DUTY_ZERO) ? PH_IN_CLOSE : PH_IN_CLOSED;
                end
                PH_IN_CLOSED: begin
                    n_inflate = 1'b1;
                    n_phase   = PH_IN_RUN;
                end
                PH_IN_STOP: begin
                    n_inflate = 1'b0;
                    n_phase   = (r_duty != DUTY_ZERO) ? PH_IN_SCLOSE : PH_IN_DONE;
                end
                PH_OUT_CLOSED, PH_OUT_OPENED, PH_IN_RUN, PH_IN_DONE: begin
                    n_phase = r_phase;
                end
                default: begin
                    // unknown phase: force everything off
                    n_duty    = DUTY_ZERO;
                    n_inflate = 1'b0;
                    n_deflate = 1'b0;
                    n_phase   = PH_IN_DONE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IN_DONE;
            r_duty      <= DUTY_ZERO;
            r_inflate   <= 1'b0;
            r_deflate   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (s_fire) begin
                r_phase   <= n_phase;
                r_duty    <= n_duty;
                r_inflate <= n_inflate;
                r_deflate <= n_deflate;
            end
            if (s_fire) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

`ifndef ASSERT_OFF
    // every accepted word yields a result in the next cycle
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_fire |=> m_axis_tvalid)
        else $error("no result after accepted word");

    // a command never touches the duty or the flags
    a_cmd_keeps_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && s_axis_tuser == KIND_COMMAND) |=>
        ($stable(r_duty) && $stable(r_inflate) && $stable(r_deflate)))
        else $error("command changed duty or flags");

    // a tick on a duty inside floor and cap moves it by at most one unless it is forced to zero
    a_duty_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_fire && s_axis_tuser == KIND_TICK && r_duty <= r_cap && r_duty >= r_floor) |=>
        (r_duty == $past(r_duty) || r_duty == $past(r_duty) + 8'd1 ||
         r_duty == $past(r_duty) - 8'd1 || r_duty == DUTY_ZERO))
        else $error("duty jumped on a tick");
`endif

endmodule

`default_nettype wire
